>>> sv/lmh_pkg.sv
package lmh_pkg;

  // Input and result transfers
  typedef struct packed {
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [3:0]         char_count;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] field_lon_char;
    logic [7:0] field_lat_char;
    logic [7:0] square_lon_digit;
    logic [7:0] square_lat_digit;
    logic [7:0] subsquare_lon_char;
    logic [7:0] subsquare_lat_char;
    logic [7:0] extended_lon_digit;
    logic [7:0] extended_lat_digit;
  } out_item_t;

  // Per-item control that travels beside the data
  typedef struct packed {
    logic ok;
    logic has_square;
    logic has_subsquare;
    logic has_extended;
  } ctl_t;

  // Scaled coordinate (3 * shifted value / 16 or / 8) and cell count widths
  localparam int unsigned YW    = 30;
  localparam int unsigned CELLW = 16;

  // Raw digit widths
  localparam int unsigned FIELDW = 5;
  localparam int unsigned SQW    = 4;
  localparam int unsigned SUBW   = 5;
  localparam int unsigned EXTW   = 4;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;

  localparam logic [7:0] FIELD_LAST  = 8'd17;
  localparam logic [7:0] SQUARE_LAST = 8'd9;

endpackage

>>> sv/lmh_prep.sv
module lmh_prep (
  input  logic             clk,
  input  logic             en,
  input  lmh_pkg::in_item_t in_item,
  output logic [lmh_pkg::YW-1:0] y_lon_r,
  output logic [lmh_pkg::YW-1:0] y_lat_r,
  output lmh_pkg::ctl_t    ctl_r
);

  localparam logic signed [31:0] LAT_LIM   = 32'sd900000000;
  localparam logic signed [31:0] LON_LIM   = 32'sd1800000000;
  localparam logic [30:0]        LAT_SPAN  = 31'd1800000000;
  localparam logic [30:0]        LAT_CLAMP = 31'd1799999990;
  localparam logic [31:0]        LON_SPAN  = 32'd3600000000;
  localparam logic [31:0]        LON_CLAMP = 32'd3599999990;

  logic              coord_ok;
  logic              len_ok;
  logic [32:0]       lat_sum;
  logic [32:0]       lon_sum;
  logic [30:0]       lat_cl;
  logic [31:0]       lon_cl;
  logic [32:0]       lat3;
  logic [33:0]       lon3;
  logic [lmh_pkg::YW-1:0] y_lon_nxt;
  logic [lmh_pkg::YW-1:0] y_lat_nxt;
  lmh_pkg::ctl_t     ctl_nxt;

  always_comb begin
    coord_ok = (in_item.latitude >= -LAT_LIM) && (in_item.latitude <= LAT_LIM) &&
               (in_item.longitude >= -LON_LIM) && (in_item.longitude <= LON_LIM);
    case (in_item.char_count)
      4'd2, 4'd4, 4'd6, 4'd8: len_ok = 1'b1;
      default:                len_ok = 1'b0;
    endcase

    // Shift into positive space
    lat_sum = {in_item.latitude[31], in_item.latitude} + 33'd900000000;
    lon_sum = {in_item.longitude[31], in_item.longitude} + 33'd1800000000;

    // Clamp at the pole and the antimeridian
    lat_cl = (lat_sum[30:0] >= LAT_SPAN) ? LAT_CLAMP : lat_sum[30:0];
    lon_cl = (lon_sum[31:0] >= LON_SPAN) ? LON_CLAMP : lon_sum[31:0];

    // cells = 3*sh / 250000 (lon) and 3*sh / 125000 (lat); take the
    // power-of-two part of the divisor here, leaving / 15625
    lat3 = {2'b00, lat_cl} + {1'b0, lat_cl, 1'b0};
    lon3 = {2'b00, lon_cl} + {1'b0, lon_cl, 1'b0};
    y_lat_nxt = lat3[32:3];
    y_lon_nxt = lon3[33:4];

    ctl_nxt.ok            = coord_ok && len_ok;
    ctl_nxt.has_square    = in_item.char_count >= 4'd4;
    ctl_nxt.has_subsquare = in_item.char_count >= 4'd6;
    ctl_nxt.has_extended  = in_item.char_count >= 4'd8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_lon_r <= y_lon_nxt;
      y_lat_r <= y_lat_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

endmodule

>>> sv/lmh_cell_div.sv
module lmh_cell_div (
  input  logic                      clk,
  input  logic [1:0]                en,
  input  logic [lmh_pkg::YW-1:0]    y,
  output logic [lmh_pkg::CELLW-1:0] cells_r
);

  // floor(y / 15625) by reciprocal: estimate is exact or one low
  localparam logic [16:0] RECIP    = 17'd68719;
  localparam logic [13:0] DIVISOR  = 14'd15625;
  localparam int unsigned PW       = lmh_pkg::YW + 17;

  logic [PW-1:0]                prod;
  logic [lmh_pkg::CELLW-1:0]    qe_nxt;
  logic [lmh_pkg::CELLW-1:0]    qe_r;
  logic [lmh_pkg::YW-1:0]       y_r;
  logic [lmh_pkg::YW-1:0]       qm;
  logic [lmh_pkg::YW-1:0]       rem;
  logic [lmh_pkg::CELLW-1:0]    cells_nxt;

  always_comb begin
    prod   = PW'(y) * PW'(RECIP);
    qe_nxt = prod[lmh_pkg::YW +: lmh_pkg::CELLW];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      qe_r <= qe_nxt;
      y_r  <= y;
    end
  end

  // Correct the estimate with one compare
  always_comb begin
    qm        = lmh_pkg::YW'(qe_r) * lmh_pkg::YW'(DIVISOR);
    rem       = y_r - qm;
    cells_nxt = qe_r + lmh_pkg::CELLW'(rem >= lmh_pkg::YW'(DIVISOR));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cells_r <= cells_nxt;
    end
  end

endmodule

>>> sv/lmh_digits.sv
module lmh_digits (
  input  logic                       clk,
  input  logic [3:0]                 en,
  input  logic [lmh_pkg::CELLW-1:0]  cells,
  output logic [lmh_pkg::FIELDW-1:0] field_r,
  output logic [lmh_pkg::SQW-1:0]    square_r,
  output logic [lmh_pkg::SUBW-1:0]   sub_r,
  output logic [lmh_pkg::EXTW-1:0]   ext_r
);

  // t = cells / 10, u = t / 24, field = u / 10, each by reciprocal,
  // exact over the cell range
  localparam logic [15:0] RECIP10  = 16'd52429;
  localparam logic [11:0] RECIP24  = 12'd2731;
  localparam logic [7:0]  RECIP10S = 8'd205;

  logic [31:0] p4;
  logic [24:0] p5;
  logic [15:0] p6;

  logic [lmh_pkg::CELLW-1:0]  c4_r;
  logic [12:0]                t4_r;
  logic [12:0]                t5_r;
  logic [7:0]                 u5_r;
  logic [lmh_pkg::EXTW-1:0]   ext5_r;
  logic [7:0]                 u6_r;
  logic [lmh_pkg::FIELDW-1:0] f6_r;
  logic [lmh_pkg::SUBW-1:0]   sub6_r;
  logic [lmh_pkg::EXTW-1:0]   ext6_r;

  logic [12:0]                t4_nxt;
  logic [7:0]                 u5_nxt;
  logic [lmh_pkg::CELLW-1:0]  ext_full;
  logic [lmh_pkg::FIELDW-1:0] f6_nxt;
  logic [12:0]                sub_full;
  logic [7:0]                 sq_full;

  always_comb begin
    p4       = 32'(cells) * 32'(RECIP10);
    t4_nxt   = p4[31:19];
    p5       = 25'(t4_r) * 25'(RECIP24);
    u5_nxt   = p5[23:16];
    ext_full = c4_r - {t4_r, 3'b000} - {2'b00, t4_r, 1'b0};
    p6       = 16'(u5_r) * 16'(RECIP10S);
    f6_nxt   = p6[15:11];
    sub_full = t5_r - {u5_r, 4'b0000} - {2'b00, u5_r, 3'b000};
    sq_full  = u6_r - {f6_r, 3'b000} - {2'b00, f6_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c4_r <= cells;
      t4_r <= t4_nxt;
    end
    if (en[1]) begin
      t5_r   <= t4_r;
      u5_r   <= u5_nxt;
      ext5_r <= ext_full[lmh_pkg::EXTW-1:0];
    end
    if (en[2]) begin
      u6_r   <= u5_r;
      f6_r   <= f6_nxt;
      sub6_r <= sub_full[lmh_pkg::SUBW-1:0];
      ext6_r <= ext5_r;
    end
    if (en[3]) begin
      field_r  <= f6_r;
      square_r <= sq_full[lmh_pkg::SQW-1:0];
      sub_r    <= sub6_r;
      ext_r    <= ext6_r;
    end
  end

endmodule

>>> sv/maidenhead_locator_encoder_unit.sv
// Channel | Ports                              | Transfer when
// input   | in_valid, in_stall, in_data        | in_valid high, in_stall low
// result  | out_valid, out_stall, out_data     | out_valid high, out_stall low
//
// Seven register stages: one transfer in per cycle while in_stall is low.
// The throughput is one item per clock; the reciprocal multipliers of the
// cell division and the digit split set the stage boundaries.
// Reset (rst_n low, synchronous) empties every stage; data registers keep junk.
// A stall holds only the full stages from the output back; empty stages
// keep filling, so bubbles close up.
module maidenhead_locator_encoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lmh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lmh_pkg::out_item_t out_data
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] en;

  lmh_pkg::ctl_t ctl0;
  lmh_pkg::ctl_t ctl_r [1:NSTG-1];

  logic [lmh_pkg::YW-1:0]     y_lon;
  logic [lmh_pkg::YW-1:0]     y_lat;
  logic [lmh_pkg::CELLW-1:0]  cells_lon;
  logic [lmh_pkg::CELLW-1:0]  cells_lat;
  logic [lmh_pkg::FIELDW-1:0] field_lon;
  logic [lmh_pkg::FIELDW-1:0] field_lat;
  logic [lmh_pkg::SQW-1:0]    sq_lon;
  logic [lmh_pkg::SQW-1:0]    sq_lat;
  logic [lmh_pkg::SUBW-1:0]   sub_lon;
  logic [lmh_pkg::SUBW-1:0]   sub_lat;
  logic [lmh_pkg::EXTW-1:0]   ext_lon;
  logic [lmh_pkg::EXTW-1:0]   ext_lat;

  // A stage loads when it is empty or the one after it moves on
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Carry control alongside the data
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctl_r[1] <= ctl0;
    end
    for (int k = 2; k < NSTG; k++) begin
      if (en[k]) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Stage 0: range check, shift, clamp, scale
  lmh_prep u_prep (
    .clk     (clk),
    .en      (en[0]),
    .in_item (in_data),
    .y_lon_r (y_lon),
    .y_lat_r (y_lat),
    .ctl_r   (ctl0)
  );

  // Stages 1-2: divide to cell counts
  lmh_cell_div u_div_lon (
    .clk     (clk),
    .en      (en[2:1]),
    .y       (y_lon),
    .cells_r (cells_lon)
  );

  lmh_cell_div u_div_lat (
    .clk     (clk),
    .en      (en[2:1]),
    .y       (y_lat),
    .cells_r (cells_lat)
  );

  // Stages 3-6: split into field, square, subsquare, extended
  lmh_digits u_dig_lon (
    .clk      (clk),
    .en       (en[6:3]),
    .cells    (cells_lon),
    .field_r  (field_lon),
    .square_r (sq_lon),
    .sub_r    (sub_lon),
    .ext_r    (ext_lon)
  );

  lmh_digits u_dig_lat (
    .clk      (clk),
    .en       (en[6:3]),
    .cells    (cells_lat),
    .field_r  (field_lat),
    .square_r (sq_lat),
    .sub_r    (sub_lat),
    .ext_r    (ext_lat)
  );

  // Form the characters from the output registers; drop unused positions
  always_comb begin
    lmh_pkg::ctl_t c;
    c = ctl_r[NSTG-1];
    out_data = '0;
    out_data.accepted = c.ok;
    if (c.ok) begin
      out_data.field_lon_char = lmh_pkg::CHAR_UPPER_A + 8'(field_lon);
      out_data.field_lat_char = lmh_pkg::CHAR_UPPER_A + 8'(field_lat);
      if (c.has_square) begin
        out_data.square_lon_digit = lmh_pkg::CHAR_ZERO + 8'(sq_lon);
        out_data.square_lat_digit = lmh_pkg::CHAR_ZERO + 8'(sq_lat);
      end
      if (c.has_subsquare) begin
        out_data.subsquare_lon_char = lmh_pkg::CHAR_LOWER_A + 8'(sub_lon);
        out_data.subsquare_lat_char = lmh_pkg::CHAR_LOWER_A + 8'(sub_lat);
      end
      if (c.has_extended) begin
        out_data.extended_lon_digit = lmh_pkg::CHAR_ZERO + 8'(ext_lon);
        out_data.extended_lat_digit = lmh_pkg::CHAR_ZERO + 8'(ext_lat);
      end
    end
  end

endmodule

>>> sv/lmh_checker.sv
module lmh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lmh_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lmh_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // An empty output never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A rejected item carries zero field bytes, square_lon and extended_lat bytes
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.field_lon_char == 8'd0 && out_data.field_lat_char == 8'd0 &&
      out_data.square_lon_digit == 8'd0 && out_data.extended_lat_digit == 8'd0)
    else $error("rejected item has non-zero bytes");

  // Field letters stay within A..R
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      out_data.field_lon_char >= lmh_pkg::CHAR_UPPER_A &&
      out_data.field_lon_char <= lmh_pkg::CHAR_UPPER_A + lmh_pkg::FIELD_LAST &&
      out_data.field_lat_char >= lmh_pkg::CHAR_UPPER_A &&
      out_data.field_lat_char <= lmh_pkg::CHAR_UPPER_A + lmh_pkg::FIELD_LAST)
    else $error("field letter out of range");

  // Input valid and payload must persist while stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transfer withdrawn or changed while stalled");

endmodule

bind maidenhead_locator_encoder_unit lmh_checker u_lmh_checker (.*);

>>> tb/maidenhead_locator_encoder_unit_test.sv
module maidenhead_locator_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lmh_pkg::*;

  // Coordinate limits and clamps, all in 1e-7 degree units
  localparam longint LAT_LIMIT     = 64'd900000000;
  localparam longint LON_LIMIT     = 64'd1800000000;
  localparam longint LAT_CLAMP     = 64'd1799999990;
  localparam longint LON_CLAMP     = 64'd3599999990;
  localparam longint UNITS_PER_DEG = 64'd10000000;

  // Locator lengths the block supports
  localparam logic [3:0] LEN_FIELD     = 4'd2;
  localparam logic [3:0] LEN_SQUARE    = 4'd4;
  localparam logic [3:0] LEN_SUBSQUARE = 4'd6;
  localparam logic [3:0] LEN_EXTENDED  = 4'd8;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned QUIET_LIMIT    = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned ITEMS_PER_PASS = 300;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Scoreboard: predicts each locator on an input transfer, checks it on a result transfer
  class locator_scoreboard;
    out_item_t   pending_locators[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Work out the locator the block should return for one position fix
    function out_item_t encode_locator(in_item_t req);
      out_item_t loc;
      longint    lat;
      longint    lon;
      longint    lat_cells;
      longint    lon_cells;
      logic      len_ok;
      loc    = '0;
      lat    = $signed(req.latitude);
      lon    = $signed(req.longitude);
      len_ok = (req.char_count == LEN_FIELD) || (req.char_count == LEN_SQUARE) ||
               (req.char_count == LEN_SUBSQUARE) || (req.char_count == LEN_EXTENDED);
      // Reject out-of-range coordinates and unsupported lengths with an all-zero result
      if (lat < -LAT_LIMIT || lat > LAT_LIMIT || lon < -LON_LIMIT || lon > LON_LIMIT ||
          !len_ok) begin
        return loc;
      end
      // Shift positive; clamp the pole and the antimeridian just below the span
      lat = lat + LAT_LIMIT;
      lon = lon + LON_LIMIT;
      if (lat >= 2 * LAT_LIMIT) lat = LAT_CLAMP;
      if (lon >= 2 * LON_LIMIT) lon = LON_CLAMP;
      lon_cells = (lon * 120) / UNITS_PER_DEG;
      lat_cells = (lat * 240) / UNITS_PER_DEG;
      loc.accepted       = 1'b1;
      loc.field_lon_char = CHAR_UPPER_A + 8'(lon_cells / 2400);
      loc.field_lat_char = CHAR_UPPER_A + 8'(lat_cells / 2400);
      if (req.char_count >= LEN_SQUARE) begin
        loc.square_lon_digit = CHAR_ZERO + 8'((lon_cells % 2400) / 240);
        loc.square_lat_digit = CHAR_ZERO + 8'((lat_cells % 2400) / 240);
      end
      if (req.char_count >= LEN_SUBSQUARE) begin
        loc.subsquare_lon_char = CHAR_LOWER_A + 8'((lon_cells % 240) / 10);
        loc.subsquare_lat_char = CHAR_LOWER_A + 8'((lat_cells % 240) / 10);
      end
      if (req.char_count >= LEN_EXTENDED) begin
        loc.extended_lon_digit = CHAR_ZERO + 8'(lon_cells % 10);
        loc.extended_lat_digit = CHAR_ZERO + 8'(lat_cells % 10);
      end
      return loc;
    endfunction

    function void note_request(in_item_t req);
      pending_locators.push_back(encode_locator(req));
    endfunction

    function string show(out_item_t r);
      return $sformatf("acc=%0b fld=%h/%h sq=%h/%h sub=%h/%h ext=%h/%h",
                       r.accepted, r.field_lon_char, r.field_lat_char,
                       r.square_lon_digit, r.square_lat_digit,
                       r.subsquare_lon_char, r.subsquare_lat_char,
                       r.extended_lon_digit, r.extended_lat_digit);
    endfunction

    function void check_locator(out_item_t got);
      out_item_t want;
      string     bad;
      if (pending_locators.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: %s", $realtime, show(got));
        return;
      end
      want = pending_locators.pop_front();
      bad  = "";
      if (got.accepted !== want.accepted)                     bad = {bad, " accepted"};
      if (got.field_lon_char !== want.field_lon_char)         bad = {bad, " field_lon"};
      if (got.field_lat_char !== want.field_lat_char)         bad = {bad, " field_lat"};
      if (got.square_lon_digit !== want.square_lon_digit)     bad = {bad, " square_lon"};
      if (got.square_lat_digit !== want.square_lat_digit)     bad = {bad, " square_lat"};
      if (got.subsquare_lon_char !== want.subsquare_lon_char) bad = {bad, " subsquare_lon"};
      if (got.subsquare_lat_char !== want.subsquare_lat_char) bad = {bad, " subsquare_lat"};
      if (got.extended_lon_digit !== want.extended_lon_digit) bad = {bad, " extended_lon"};
      if (got.extended_lat_digit !== want.extended_lat_digit) bad = {bad, " extended_lat"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
                   $realtime, bad, show(want), show(got));
      end
    endfunction

    function int unsigned outstanding();
      return pending_locators.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (pending_locators.size() == 0);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  locator_scoreboard sb;

  // Idling rates in percent, changed between passes
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  // Set by the stimulus to ask the receiver for one long hold-off
  bit          hold_off_req    = 1'b0;

  maidenhead_locator_encoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Build one position fix from plain coordinates
  function automatic in_item_t make_fix(logic [31:0] lat, logic [31:0] lon, logic [3:0] len);
    in_item_t req;
    req.latitude   = lat;
    req.longitude  = lon;
    req.char_count = len;
    return req;
  endfunction

  // Mostly well-formed fixes with random content; the rest edges, bad lengths and noise
  function automatic in_item_t random_fix();
    in_item_t    req;
    int unsigned pick;
    logic [31:0] edge_vals[5];
    logic [3:0]  lengths[4];
    lengths   = '{LEN_FIELD, LEN_SQUARE, LEN_SUBSQUARE, LEN_EXTENDED};
    pick      = $urandom_range(99);
    req.latitude   = $urandom;
    req.longitude  = $urandom;
    req.char_count = $urandom_range(15);
    if (pick < 85) begin
      req.latitude  = $urandom_range(32'd1800000000) - 32'd900000000;
      req.longitude = $urandom_range(32'd3600000000) - 32'd1800000000;
      if (pick < 70) req.char_count = lengths[$urandom_range(3)];
    end else if (pick < 95) begin
      // Hug the limits of the coordinate range on either side
      edge_vals     = '{32'd900000000, 32'd900000001, -32'd900000000, -32'd900000001, 32'd0};
      req.latitude  = edge_vals[$urandom_range(4)];
      edge_vals     = '{32'd1800000000, 32'd1800000001, -32'd1800000000, -32'd1800000001,
                        32'd0};
      req.longitude = edge_vals[$urandom_range(4)];
      req.char_count = lengths[$urandom_range(3)];
    end
    return req;
  endfunction

  // Offer one fix, idling first at the sender's rate, and hold it until it transfers
  task automatic send_item(in_item_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic run_pass(int unsigned idle_pct, int unsigned hold_pct);
    sender_idle_pct = idle_pct;
    stall_pct       = hold_pct;
    repeat (ITEMS_PER_PASS) send_item(random_fix());
  endtask

  // Receiver: stall at random, or hold off for a long stretch when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_locator(out_data);
  end

  // Watchdog: give up once nothing has transferred for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("maidenhead_locator_encoder_unit_test NOT OK");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed fixes: every length, the clamps, the range limits and bad lengths
    send_item(make_fix(32'd0, 32'd0, LEN_FIELD));
    send_item(make_fix(32'd0, 32'd0, LEN_SQUARE));
    send_item(make_fix(32'd0, 32'd0, LEN_SUBSQUARE));
    send_item(make_fix(32'd0, 32'd0, LEN_EXTENDED));
    // North pole and antimeridian land on the clamp
    send_item(make_fix(32'd900000000, 32'd1800000000, LEN_EXTENDED));
    send_item(make_fix(32'd900000000, 32'd0, LEN_FIELD));
    send_item(make_fix(32'd0, 32'd1800000000, LEN_SQUARE));
    send_item(make_fix(-32'd900000000, -32'd1800000000, LEN_EXTENDED));
    send_item(make_fix(32'd899999999, 32'd1799999999, LEN_EXTENDED));
    // Just outside the range on each side, and the extremes of the field
    send_item(make_fix(32'd900000001, 32'd0, LEN_EXTENDED));
    send_item(make_fix(-32'd900000001, 32'd0, LEN_EXTENDED));
    send_item(make_fix(32'd0, 32'd1800000001, LEN_EXTENDED));
    send_item(make_fix(32'd0, -32'd1800000001, LEN_EXTENDED));
    send_item(make_fix(32'h8000_0000, 32'h8000_0000, LEN_EXTENDED));
    send_item(make_fix(32'h7fff_ffff, 32'h7fff_ffff, LEN_SQUARE));
    // Unsupported lengths
    send_item(make_fix(32'd0, 32'd0, 4'd0));
    send_item(make_fix(32'd0, 32'd0, 4'd1));
    send_item(make_fix(32'd0, 32'd0, 4'd3));
    send_item(make_fix(32'd0, 32'd0, 4'd7));
    send_item(make_fix(32'd0, 32'd0, 4'd9));
    send_item(make_fix(32'd0, 32'd0, 4'd15));
    // Ordinary positions in both hemispheres
    send_item(make_fix(32'd515000000, -32'd1270000, LEN_EXTENDED));
    send_item(make_fix(-32'd338688000, 32'd1512093000, LEN_SUBSQUARE));

    // Keep offering while the receiver holds off, so the pipe fills and stalls the input
    hold_off_req = 1'b1;
    run_pass(0, 0);
    run_pass(72, 0);
    run_pass(0, 72);
    run_pass(10, 10);
    in_valid <= 1'b0;

    // Drain: wait for every prediction to be met, then a little longer for strays
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.clean())
      $display("maidenhead_locator_encoder_unit_test OK");
    else
      $display("maidenhead_locator_encoder_unit_test NOT OK");
    $finish;
  end

endmodule
